// ===== hdl/hbek_pkg.sv =====
// Shared widths, payload types and status codes of the hydrogen-bond energy kernel.
`default_nettype none

package hbek_pkg;

   // Coordinate and energy widths of the channel words.
   localparam int COORD_WIDTH  = 20;
   localparam int ENERGY_WIDTH = 24;

   typedef logic signed [COORD_WIDTH-1:0]  coord_type;
   typedef logic signed [ENERGY_WIDTH-1:0] energy_type;
   typedef logic [1:0]                     status_type;

   // Result status codes.
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_ZERO_DIST  = 2'd1;
   localparam status_type STATUS_DEGENERATE = 2'd2;
   localparam status_type STATUS_SATURATED  = 2'd3;

   // Saturation limits and the reset value of the cutoff register (-0.5 kcal/mol).
   localparam energy_type ENERGY_MAX   = 24'sh7FFFFF;
   localparam energy_type ENERGY_MIN   = 24'sh800000;
   localparam energy_type CUTOFF_RESET = -24'sd32768;

endpackage

`default_nettype wire

// ===== hdl/hbek_if.sv =====
// Channel interfaces of the hydrogen-bond energy kernel: pair input, result and cutoff write.
`default_nettype none

interface hbek_req_if;
   import hbek_pkg::*;
   logic      valid;
   logic      ready;
   coord_type donor_nitrogen_x;
   coord_type donor_nitrogen_y;
   coord_type donor_nitrogen_z;
   coord_type donor_hydrogen_x;
   coord_type donor_hydrogen_y;
   coord_type donor_hydrogen_z;
   coord_type acceptor_oxygen_x;
   coord_type acceptor_oxygen_y;
   coord_type acceptor_oxygen_z;
   coord_type acceptor_carbon_x;
   coord_type acceptor_carbon_y;
   coord_type acceptor_carbon_z;

   modport source (
      output valid,
      output donor_nitrogen_x, donor_nitrogen_y, donor_nitrogen_z,
      output donor_hydrogen_x, donor_hydrogen_y, donor_hydrogen_z,
      output acceptor_oxygen_x, acceptor_oxygen_y, acceptor_oxygen_z,
      output acceptor_carbon_x, acceptor_carbon_y, acceptor_carbon_z,
      input  ready
   );
   modport sink (
      input  valid,
      input  donor_nitrogen_x, donor_nitrogen_y, donor_nitrogen_z,
      input  donor_hydrogen_x, donor_hydrogen_y, donor_hydrogen_z,
      input  acceptor_oxygen_x, acceptor_oxygen_y, acceptor_oxygen_z,
      input  acceptor_carbon_x, acceptor_carbon_y, acceptor_carbon_z,
      output ready
   );
endinterface

interface hbek_rsp_if;
   import hbek_pkg::*;
   logic       valid;
   logic       ready;
   energy_type bond_energy;
   status_type status;
   logic       accepted;

   modport source (output valid, output bond_energy, output status, output accepted,
                   input ready);
   modport sink (input valid, input bond_energy, input status, input accepted,
                 output ready);
endinterface

interface hbek_csr_if;
   import hbek_pkg::*;
   logic       valid;
   logic       ready;
   energy_type energy_cutoff;

   modport source (output valid, output energy_cutoff, input ready);
   modport sink (input valid, input energy_cutoff, output ready);
endinterface

`default_nettype wire

// ===== hdl/hbond_energy_kernel.sv =====
// Top level of the hydrogen-bond energy kernel: a 40-stage pipeline from pair to energy.
//
// Usage:
// - req carries one donor/acceptor pair word: N, H, O and C positions in signed
//   angstroms with 8 fraction bits. A word is taken when req.valid and req.ready
//   are both high.
// - rsp returns one word per pair, in order: bond_energy (signed Q7.16), status
//   and accepted. It is taken when rsp.valid and rsp.ready are both high.
// - csr writes the acceptance cutoff; it is always ready. Write it only while no
//   pair is in flight.
// - One pair enters every cycle unless rsp stalls; the 26-step radial divider
//   and the 17-step angle dividers are unrolled into pipeline stages, so
//   throughput is one word per clock while rsp does not stall.
// - Every stage has its own valid bit and loads when it is empty or its
//   successor moves. When rsp stalls, words pack up behind the output register
//   and req.ready only falls once all 40 stages hold a word.
// - Synchronous reset empties the pipeline and sets the cutoff to -0.5 kcal/mol.
`default_nettype none

module hbond_energy_kernel (
   input  wire logic   clock,
   input  wire logic   reset,
   hbek_req_if.sink    req,
   hbek_rsp_if.source  rsp,
   hbek_csr_if.sink    csr
);
   import hbek_pkg::*;

   // Datapath widths and constants.
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int SHIFT_WIDTH  = $clog2(COORD_WIDTH);
   localparam int DIR_BITS     = 14;
   localparam int DIR_WIDTH    = DIR_BITS + 1;
   localparam int DOT_WIDTH    = 31;
   localparam int NORM_WIDTH   = 30;
   localparam int WIDE_WIDTH   = 60;
   localparam int AQ_WIDTH     = 17;
   localparam int ADIV_STEPS   = 17;
   localparam int FAR_SHIFT    = 16;
   localparam int SQ_WIDTH     = 32;
   localparam int DSQ_WIDTH    = 34;
   localparam int S_WIDTH      = 26;
   localparam int RDIV_STEPS   = S_WIDTH;
   localparam int S2_WIDTH     = 31;
   localparam int S3_WIDTH     = 36;
   localparam int T_WIDTH      = 27;
   localparam int M_WIDTH      = 39;
   localparam int RAD_WIDTH    = 41;
   localparam int Q_FRAC       = 16;
   localparam logic [DSQ_WIDTH-1:0] RDIV_INIT   = 34'd9216;
   localparam logic [S_WIDTH-1:0]   S_CAP       = 26'd41943040;
   localparam logic [T_WIDTH:0]     FOUR_Q20    = 28'd4194304;
   localparam logic [17:0]          WELL_DEPTH  = 18'd183501;
   localparam logic [RAD_WIDTH-1:0] RADIAL_CAP  = 41'h100_0000_0000;

   // Stage positions.
   localparam int ST_WIDE    = 3;
   localparam int ST_CAP     = ST_WIDE + RDIV_STEPS + 1;
   localparam int ST_SQ      = ST_CAP + 1;
   localparam int ST_CUBE    = ST_CAP + 2;
   localparam int ST_TPROD   = ST_CAP + 3;
   localparam int ST_M       = ST_CAP + 4;
   localparam int ST_RPROD   = ST_CAP + 5;
   localparam int ST_RAD     = ST_CAP + 6;
   localparam int ST_EPROD   = ST_CAP + 7;
   localparam int ST_SAT     = ST_CAP + 8;
   localparam int ST_OUT     = ST_CAP + 9;
   localparam int NUM_STAGES = ST_OUT + 1;
   localparam int SIDE_N     = ST_SAT - ST_CAP;

   typedef logic signed [DIFF_WIDTH-1:0] diff_type;
   typedef logic [COORD_WIDTH-1:0]       mag_type;
   typedef logic [SHIFT_WIDTH-1:0]       shift_type;
   typedef logic signed [DIR_WIDTH-1:0]  dir_type;
   typedef logic signed [DOT_WIDTH-1:0]  dot_type;
   typedef logic [NORM_WIDTH-1:0]        norm_type;
   typedef logic [WIDE_WIDTH-1:0]        wide_type;

   typedef struct packed {
      status_type             code;
      logic                   far;
      logic                   sat;
      logic [DSQ_WIDTH-1:0]   dsq;
      logic [DSQ_WIDTH-1:0]   rrem;
      logic [S_WIDTH-1:0]     rq;
      logic                   neg1;
      logic                   neg2;
      wide_type               arem1;
      wide_type               aden1;
      wide_type               arem2;
      wide_type               aden2;
      logic [AQ_WIDTH-1:0]    aq1;
      logic [AQ_WIDTH-1:0]    aq2;
   } div_type;

   typedef struct packed {
      status_type          code;
      logic                far;
      logic                positive;
      logic [AQ_WIDTH-1:0] fac;
   } side_type;

   function automatic mag_type mag_of(diff_type d);
      diff_type n;
      n = -d;
      return d[DIFF_WIDTH-1] ? mag_type'(n) : mag_type'(d);
   endfunction

   // Shift that brings the largest magnitude of a vector below 2^14.
   function automatic shift_type shrink_shift(mag_type m0, mag_type m1, mag_type m2);
      mag_type   top;
      shift_type sh;
      top = m0;
      if (m1 > top) top = m1;
      if (m2 > top) top = m2;
      sh = '0;
      for (int i = DIR_BITS; i < COORD_WIDTH; i++) begin
         if (top[i]) sh = shift_type'(i - DIR_BITS + 1);
      end
      return sh;
   endfunction

   function automatic dir_type shrink_one(diff_type d, mag_type m, shift_type sh);
      mag_type s;
      dir_type v;
      s = m >> sh;
      v = dir_type'({1'b0, DIR_BITS'(s)});
      return d[DIFF_WIDTH-1] ? -v : v;
   endfunction

   // One restoring step of the radial divider and, for early steps, the angle dividers.
   function automatic div_type div_step(div_type p, int k);
      div_type                n;
      logic [DSQ_WIDTH:0]     r2;
      logic [WIDE_WIDTH:0]    a2;
      logic [WIDE_WIDTH:0]    b2;
      n = p;
      r2 = {p.rrem, 1'b0};
      if (r2 >= {1'b0, p.dsq}) begin
         n.rrem = DSQ_WIDTH'(r2 - {1'b0, p.dsq});
         n.rq   = {p.rq[S_WIDTH-2:0], 1'b1};
      end else begin
         n.rrem = DSQ_WIDTH'(r2);
         n.rq   = {p.rq[S_WIDTH-2:0], 1'b0};
      end
      if (k == 0) begin
         if (p.arem1 >= p.aden1) begin
            n.arem1 = p.arem1 - p.aden1;
            n.aq1   = AQ_WIDTH'(1);
         end
         if (p.arem2 >= p.aden2) begin
            n.arem2 = p.arem2 - p.aden2;
            n.aq2   = AQ_WIDTH'(1);
         end
      end else if (k < ADIV_STEPS) begin
         a2 = {p.arem1, 1'b0};
         b2 = {p.arem2, 1'b0};
         if (a2 >= {1'b0, p.aden1}) begin
            n.arem1 = WIDE_WIDTH'(a2 - {1'b0, p.aden1});
            n.aq1   = {p.aq1[AQ_WIDTH-2:0], 1'b1};
         end else begin
            n.arem1 = WIDE_WIDTH'(a2);
            n.aq1   = {p.aq1[AQ_WIDTH-2:0], 1'b0};
         end
         if (b2 >= {1'b0, p.aden2}) begin
            n.arem2 = WIDE_WIDTH'(b2 - {1'b0, p.aden2});
            n.aq2   = {p.aq2[AQ_WIDTH-2:0], 1'b1};
         end else begin
            n.arem2 = WIDE_WIDTH'(b2);
            n.aq2   = {p.aq2[AQ_WIDTH-2:0], 1'b0};
         end
      end
      return n;
   endfunction

   // Pipeline flow control: a stage loads when it is empty or its word moves on.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (stage_en & valid_in) | (~stage_en & valid_ff);
      end
   end

   assign req.ready = stage_en[0];
   assign rsp.valid = valid_ff[NUM_STAGES-1];

   // Cutoff register.
   energy_type cutoff_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr.valid) begin
         cutoff_ff <= csr.energy_cutoff;
      end
   end

   // Stage 0: difference vectors N-O, N-H, O-H and O-C.
   diff_type no_ff [3];
   diff_type nh_ff [3];
   diff_type oh_ff [3];
   diff_type oc_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         no_ff[0] <= diff_type'(req.donor_nitrogen_x) - diff_type'(req.acceptor_oxygen_x);
         no_ff[1] <= diff_type'(req.donor_nitrogen_y) - diff_type'(req.acceptor_oxygen_y);
         no_ff[2] <= diff_type'(req.donor_nitrogen_z) - diff_type'(req.acceptor_oxygen_z);
         nh_ff[0] <= diff_type'(req.donor_nitrogen_x) - diff_type'(req.donor_hydrogen_x);
         nh_ff[1] <= diff_type'(req.donor_nitrogen_y) - diff_type'(req.donor_hydrogen_y);
         nh_ff[2] <= diff_type'(req.donor_nitrogen_z) - diff_type'(req.donor_hydrogen_z);
         oh_ff[0] <= diff_type'(req.acceptor_oxygen_x) - diff_type'(req.donor_hydrogen_x);
         oh_ff[1] <= diff_type'(req.acceptor_oxygen_y) - diff_type'(req.donor_hydrogen_y);
         oh_ff[2] <= diff_type'(req.acceptor_oxygen_z) - diff_type'(req.donor_hydrogen_z);
         oc_ff[0] <= diff_type'(req.acceptor_oxygen_x) - diff_type'(req.acceptor_carbon_x);
         oc_ff[1] <= diff_type'(req.acceptor_oxygen_y) - diff_type'(req.acceptor_carbon_y);
         oc_ff[2] <= diff_type'(req.acceptor_oxygen_z) - diff_type'(req.acceptor_carbon_z);
      end
   end

   // Stage 1: geometry checks, N-O component squares, shrunk direction vectors.
   mag_type               no_mag [3];
   mag_type               nh_mag [3];
   mag_type               oh_mag [3];
   mag_type               oc_mag [3];
   shift_type             sh_h;
   shift_type             sh_o;
   shift_type             sh_c;
   status_type            code1_in;
   logic                  far1_in;
   status_type            code1_ff;
   logic                  far1_ff;
   logic [SQ_WIDTH-1:0]   sq_ff [3];
   dir_type               hv_ff [3];
   dir_type               ov_ff [3];
   dir_type               cv_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         no_mag[i] = mag_of(no_ff[i]);
         nh_mag[i] = mag_of(nh_ff[i]);
         oh_mag[i] = mag_of(oh_ff[i]);
         oc_mag[i] = mag_of(oc_ff[i]);
      end
      sh_h = shrink_shift(nh_mag[0], nh_mag[1], nh_mag[2]);
      sh_o = shrink_shift(oh_mag[0], oh_mag[1], oh_mag[2]);
      sh_c = shrink_shift(oc_mag[0], oc_mag[1], oc_mag[2]);
      far1_in = ((no_mag[0] >> FAR_SHIFT) != '0) || ((no_mag[1] >> FAR_SHIFT) != '0) ||
                ((no_mag[2] >> FAR_SHIFT) != '0);
      if (no_mag[0] == '0 && no_mag[1] == '0 && no_mag[2] == '0) begin
         code1_in = STATUS_ZERO_DIST;
      end else if ((nh_mag[0] == '0 && nh_mag[1] == '0 && nh_mag[2] == '0) ||
                   (oh_mag[0] == '0 && oh_mag[1] == '0 && oh_mag[2] == '0) ||
                   (oc_mag[0] == '0 && oc_mag[1] == '0 && oc_mag[2] == '0)) begin
         code1_in = STATUS_DEGENERATE;
      end else begin
         code1_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         code1_ff <= code1_in;
         far1_ff  <= far1_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= {16'd0, 16'(no_mag[i])} * {16'd0, 16'(no_mag[i])};
            hv_ff[i] <= shrink_one(nh_ff[i], nh_mag[i], sh_h);
            ov_ff[i] <= shrink_one(oh_ff[i], oh_mag[i], sh_o);
            cv_ff[i] <= shrink_one(oc_ff[i], oc_mag[i], sh_c);
         end
      end
   end

   // Stage 2: squared distance, dot products and squared norms.
   status_type           code2_ff;
   logic                 far2_ff;
   logic [DSQ_WIDTH-1:0] dsq2_ff;
   dot_type              dot1_ff;
   dot_type              dot2_ff;
   norm_type             norm_h_ff;
   norm_type             norm_o_ff;
   norm_type             norm_c_ff;
   dot_type              nrm_h_in;
   dot_type              nrm_o_in;
   dot_type              nrm_c_in;

   always_comb begin
      nrm_h_in = dot_type'(hv_ff[0]) * dot_type'(hv_ff[0]) +
                 dot_type'(hv_ff[1]) * dot_type'(hv_ff[1]) +
                 dot_type'(hv_ff[2]) * dot_type'(hv_ff[2]);
      nrm_o_in = dot_type'(ov_ff[0]) * dot_type'(ov_ff[0]) +
                 dot_type'(ov_ff[1]) * dot_type'(ov_ff[1]) +
                 dot_type'(ov_ff[2]) * dot_type'(ov_ff[2]);
      nrm_c_in = dot_type'(cv_ff[0]) * dot_type'(cv_ff[0]) +
                 dot_type'(cv_ff[1]) * dot_type'(cv_ff[1]) +
                 dot_type'(cv_ff[2]) * dot_type'(cv_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         code2_ff  <= code1_ff;
         far2_ff   <= far1_ff;
         dsq2_ff   <= DSQ_WIDTH'(sq_ff[0]) + DSQ_WIDTH'(sq_ff[1]) + DSQ_WIDTH'(sq_ff[2]);
         dot1_ff   <= dot_type'(hv_ff[0]) * dot_type'(ov_ff[0]) +
                      dot_type'(hv_ff[1]) * dot_type'(ov_ff[1]) +
                      dot_type'(hv_ff[2]) * dot_type'(ov_ff[2]);
         dot2_ff   <= dot_type'(cv_ff[0]) * dot_type'(ov_ff[0]) +
                      dot_type'(cv_ff[1]) * dot_type'(ov_ff[1]) +
                      dot_type'(cv_ff[2]) * dot_type'(ov_ff[2]);
         norm_h_ff <= NORM_WIDTH'(nrm_h_in);
         norm_o_ff <= NORM_WIDTH'(nrm_o_in);
         norm_c_ff <= NORM_WIDTH'(nrm_c_in);
      end
   end

   // Stage 3: divider operands; then one quotient bit per stage.
   div_type dv_ff [RDIV_STEPS+1];
   div_type dv0_in;
   dot_type dmag1;
   dot_type dmag2;

   always_comb begin
      dmag1 = dot1_ff[DOT_WIDTH-1] ? -dot1_ff : dot1_ff;
      dmag2 = dot2_ff[DOT_WIDTH-1] ? -dot2_ff : dot2_ff;
      dv0_in.code  = code2_ff;
      dv0_in.far   = far2_ff;
      dv0_in.sat   = dsq2_ff <= RDIV_INIT;
      dv0_in.dsq   = dsq2_ff;
      dv0_in.rrem  = RDIV_INIT;
      dv0_in.rq    = '0;
      dv0_in.neg1  = dot1_ff[DOT_WIDTH-1];
      dv0_in.neg2  = dot2_ff[DOT_WIDTH-1];
      dv0_in.arem1 = wide_type'(NORM_WIDTH'(dmag1)) * wide_type'(NORM_WIDTH'(dmag1));
      dv0_in.aden1 = wide_type'(norm_h_ff) * wide_type'(norm_o_ff);
      dv0_in.arem2 = wide_type'(NORM_WIDTH'(dmag2)) * wide_type'(NORM_WIDTH'(dmag2));
      dv0_in.aden2 = wide_type'(norm_c_ff) * wide_type'(norm_o_ff);
      dv0_in.aq1   = '0;
      dv0_in.aq2   = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_WIDE]) begin
         dv_ff[0] <= dv0_in;
      end
   end

   for (genvar g = 1; g <= RDIV_STEPS; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (stage_en[ST_WIDE+g]) begin
            dv_ff[g] <= div_step(dv_ff[g-1], g - 1);
         end
      end
   end

   // Side information that rides along the radial multiplier chain.
   side_type side_ff [SIDE_N];

   for (genvar g = 2; g < SIDE_N; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (stage_en[ST_CAP+g]) begin
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   // Cap s and form the combined angle factor.
   logic [S_WIDTH-1:0]      s_cap_in;
   logic [AQ_WIDTH-1:0]     f1_in;
   logic [AQ_WIDTH-1:0]     f2_in;
   logic [2*AQ_WIDTH-1:0]   fprod_in;
   logic [S_WIDTH-1:0]      s_a_ff;

   always_comb begin
      s_cap_in = (dv_ff[RDIV_STEPS].sat || dv_ff[RDIV_STEPS].rq > S_CAP) ? S_CAP
                                                                         : dv_ff[RDIV_STEPS].rq;
      f1_in    = dv_ff[RDIV_STEPS].neg1 ? dv_ff[RDIV_STEPS].aq1 : '0;
      f2_in    = dv_ff[RDIV_STEPS].neg2 ? dv_ff[RDIV_STEPS].aq2 : '0;
      fprod_in = {{AQ_WIDTH{1'b0}}, f1_in} * {{AQ_WIDTH{1'b0}}, f2_in};
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_CAP]) begin
         s_a_ff           <= s_cap_in;
         side_ff[0].code  <= dv_ff[RDIV_STEPS].code;
         side_ff[0].far   <= dv_ff[RDIV_STEPS].far;
         side_ff[0].positive <= 1'b0;
         side_ff[0].fac   <= fprod_in[AQ_WIDTH+Q_FRAC-1:Q_FRAC];
      end
   end

   // s^2 and the well term |4 - 3s| with its sign.
   logic [2*S_WIDTH-1:0] sprod_in;
   logic [T_WIDTH:0]     three_s_in;
   logic                 positive_in;
   logic [T_WIDTH:0]     tdiff_in;
   logic [S_WIDTH-1:0]   s_b_ff;
   logic [S2_WIDTH-1:0]  s2_ff;
   logic [T_WIDTH-1:0]   t_b_ff;

   always_comb begin
      sprod_in    = {{S_WIDTH{1'b0}}, s_a_ff} * {{S_WIDTH{1'b0}}, s_a_ff};
      three_s_in  = {2'b00, s_a_ff} + {1'b0, s_a_ff, 1'b0};
      positive_in = three_s_in > FOUR_Q20;
      tdiff_in    = positive_in ? three_s_in - FOUR_Q20 : FOUR_Q20 - three_s_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SQ]) begin
         s_b_ff  <= s_a_ff;
         s2_ff   <= sprod_in[S2_WIDTH+19:20];
         t_b_ff  <= T_WIDTH'(tdiff_in);
         side_ff[1].code     <= side_ff[0].code;
         side_ff[1].far      <= side_ff[0].far;
         side_ff[1].fac      <= side_ff[0].fac;
         side_ff[1].positive <= positive_in;
      end
   end

   // s^3.
   logic [S2_WIDTH+S_WIDTH-1:0] s3prod_in;
   logic [S3_WIDTH-1:0]         s3_ff;
   logic [T_WIDTH-1:0]          t_c_ff;

   assign s3prod_in = (S2_WIDTH+S_WIDTH)'(s2_ff) * (S2_WIDTH+S_WIDTH)'(s_b_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_CUBE]) begin
         s3_ff  <= s3prod_in[S3_WIDTH+19:20];
         t_c_ff <= t_b_ff;
      end
   end

   // s^3 * t as two partial products.
   logic [18+T_WIDTH-1:0] tp_lo_ff;
   logic [18+T_WIDTH-1:0] tp_hi_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_TPROD]) begin
         tp_lo_ff <= (18+T_WIDTH)'(s3_ff[17:0]) * (18+T_WIDTH)'(t_c_ff);
         tp_hi_ff <= (18+T_WIDTH)'(s3_ff[35:18]) * (18+T_WIDTH)'(t_c_ff);
      end
   end

   // m = (s^3 * t) >> 24.
   logic [62:0]          psum_in;
   logic [M_WIDTH-1:0]   m_ff;

   assign psum_in = (63'(tp_hi_ff) << 18) + 63'(tp_lo_ff);

   always_ff @(posedge clock) begin
      if (stage_en[ST_M]) begin
         m_ff <= psum_in[62:24];
      end
   end

   // m * 2.8 as two partial products.
   logic [41:0] rp_lo_ff;
   logic [32:0] rp_hi_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_RPROD]) begin
         rp_lo_ff <= 42'(m_ff[23:0]) * 42'(WELL_DEPTH);
         rp_hi_ff <= 33'(m_ff[38:24]) * 33'(WELL_DEPTH);
      end
   end

   // Radial magnitude, capped, and zero for a far pair.
   logic [56:0]          rsum_in;
   logic [RAD_WIDTH-1:0] rraw_in;
   logic [RAD_WIDTH-1:0] rad_ff;

   always_comb begin
      rsum_in = (57'(rp_hi_ff) << 24) + 57'(rp_lo_ff);
      rraw_in = rsum_in[56:16];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_RAD]) begin
         if (side_ff[ST_RAD-ST_CAP-1].far) begin
            rad_ff <= '0;
         end else begin
            rad_ff <= (rraw_in > RADIAL_CAP) ? RADIAL_CAP : rraw_in;
         end
      end
   end

   // Radial times angle factor as two partial products.
   logic [40:0] ep_lo_ff;
   logic [33:0] ep_hi_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_EPROD]) begin
         ep_lo_ff <= 41'(rad_ff[23:0]) * 41'(side_ff[ST_EPROD-ST_CAP-1].fac);
         ep_hi_ff <= 34'(rad_ff[40:24]) * 34'(side_ff[ST_EPROD-ST_CAP-1].fac);
      end
   end

   // Energy, sign, saturation and status.
   logic [57:0]  esum_in;
   logic [41:0]  emag_in;
   energy_type   val_in;
   status_type   stat_in;
   energy_type   val_ff;
   status_type   stat_ff;
   side_type     side_sat;

   always_comb begin
      side_sat = side_ff[ST_SAT-ST_CAP-1];
      esum_in  = (58'(ep_hi_ff) << 24) + 58'(ep_lo_ff);
      emag_in  = esum_in[57:16];
      stat_in  = STATUS_OK;
      if (side_sat.positive) begin
         if (emag_in > 42'(ENERGY_MAX)) begin
            val_in  = ENERGY_MAX;
            stat_in = STATUS_SATURATED;
         end else begin
            val_in = energy_type'(emag_in[ENERGY_WIDTH-1:0]);
         end
      end else begin
         if (emag_in > 42'h80_0000) begin
            val_in  = ENERGY_MIN;
            stat_in = STATUS_SATURATED;
         end else begin
            val_in = -energy_type'(emag_in[ENERGY_WIDTH-1:0]);
         end
      end
      if (side_sat.code != STATUS_OK) begin
         val_in  = '0;
         stat_in = side_sat.code;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SAT]) begin
         val_ff  <= val_in;
         stat_ff <= stat_in;
      end
   end

   // Output register with the cutoff test.
   energy_type bond_energy_ff;
   status_type status_ff;
   logic       accepted_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         bond_energy_ff <= val_ff;
         status_ff      <= stat_ff;
         accepted_ff    <= (stat_ff == STATUS_OK) && (val_ff <= cutoff_ff);
      end
   end

   assign rsp.bond_energy = bond_energy_ff;
   assign rsp.status      = status_ff;
   assign rsp.accepted    = accepted_ff;

`ifndef SYNTHESIS
   // Geometry errors carry a zero energy and are never accepted.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == STATUS_ZERO_DIST || rsp.status == STATUS_DEGENERATE)
      |-> rsp.bond_energy == '0 && !rsp.accepted)
      else $error("error status with nonzero energy or acceptance");

   // Acceptance needs a clean status.
   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.accepted |-> rsp.status == STATUS_OK)
      else $error("accepted word with nonzero status");

   // A saturated word holds one of the two rail values.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == STATUS_SATURATED
      |-> rsp.bond_energy == ENERGY_MAX || rsp.bond_energy == ENERGY_MIN)
      else $error("saturated status without a rail value");

   // The input only backs up when the output is held by the receiver.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid && !rsp.ready)
      else $error("input stalled while the output moves");
`endif

endmodule

`default_nettype wire

// ===== tb/hbek_checker.sv =====
// Checker for the hydrogen-bond energy kernel: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps
`default_nettype none

module hbek_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   hbek_req_if.sink   req_mon,
   hbek_rsp_if.sink   rsp_mon,
   hbek_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending_count,
   output int         result_count,
   output int         saturated_count,
   output int         taken_count
);
   import hbek_pkg::*;

   typedef struct packed {
      energy_type energy;
      status_type status;
      logic       accepted;
   } bond_result_type;

   bond_result_type    energy_queue[$];
   logic signed [23:0] cutoff_shadow;

   // Report one mismatch on a single line and count it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Halve all magnitudes of a direction vector until its largest one fits in 14 bits.
   function automatic void shrink_dir(input longint v[3], output longint o[3]);
      longint unsigned m[3];
      longint unsigned top;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > top) top = m[i];
      end
      while (top > 16383) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         top = top >> 1;
      end
      for (int i = 0; i < 3; i++) o[i] = v[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
   endfunction

   // Squared cosine in Q1.16, zero unless the vectors point against each other.
   function automatic longint unsigned cos_sq_factor(input longint a[3], input longint b[3]);
      longint x[3], y[3];
      longint d, na, nb;
      longint unsigned num, den, q, rem;
      shrink_dir(a, x);
      shrink_dir(b, y);
      d = x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
      if (d >= 0) return 0;
      na = x[0]*x[0] + x[1]*x[1] + x[2]*x[2];
      nb = y[0]*y[0] + y[1]*y[1] + y[2]*y[2];
      den = longint'(na) * longint'(nb);
      if (den == 0) return 0;
      num = (-d) * (-d);
      q = 0;
      rem = num;
      if (rem >= den) begin
         rem -= den;
         q = 1;
      end
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem -= den;
            q |= 1;
         end
      end
      return q;
   endfunction

   function automatic logic bool_zero(input longint v[3]);
      return v[0] == 0 && v[1] == 0 && v[2] == 0;
   endfunction

   // Bond energy of one pair from its twelve coordinates.
   function automatic bond_result_type predict_bond(input longint c[12],
                                                    input logic signed [23:0] cutoff);
      longint no[3], nh[3], oh[3], oc[3];
      bond_result_type r;
      longint unsigned rad, fac, e, dsq, s, s2, s3, t, m, mag;
      logic positive, far;
      longint val;
      for (int i = 0; i < 3; i++) begin
         no[i] = c[i] - c[6+i];
         nh[i] = c[i] - c[3+i];
         oh[i] = c[6+i] - c[3+i];
         oc[i] = c[6+i] - c[9+i];
      end
      r = '0;
      r.status = STATUS_OK;
      if (bool_zero(no)) begin
         r.status = STATUS_ZERO_DIST;
         return r;
      end
      if (bool_zero(nh) || bool_zero(oh) || bool_zero(oc)) begin
         r.status = STATUS_DEGENERATE;
         return r;
      end
      rad = 0;
      positive = 1'b0;
      far = 1'b0;
      dsq = 0;
      for (int i = 0; i < 3; i++) begin
         mag = no[i] < 0 ? -no[i] : no[i];
         if (mag >= 65536) far = 1'b1;
         dsq += mag * mag;
      end
      if (!far) begin
         s = (64'd9 << 36) / dsq;
         if (s > (64'd40 << 20)) s = 64'd40 << 20;
         s2 = (s * s) >> 20;
         s3 = (s2 * s) >> 20;
         if (3 * s > (64'd4 << 20)) begin
            t = 3 * s - (64'd4 << 20);
            positive = 1'b1;
         end else begin
            t = (64'd4 << 20) - 3 * s;
         end
         m = (s3 * t) >> 24;
         rad = (m * 64'd183501) >> 16;
         if (rad > (64'd1 << 40)) rad = 64'd1 << 40;
      end
      fac = (cos_sq_factor(nh, oh) * cos_sq_factor(oc, oh)) >> 16;
      e = (rad * fac) >> 16;
      if (positive) begin
         if (e > 8388607) begin
            e = 8388607;
            r.status = STATUS_SATURATED;
         end
         val = e;
      end else begin
         if (e > 8388608) begin
            e = 8388608;
            r.status = STATUS_SATURATED;
         end
         val = -longint'(e);
      end
      r.energy = val[23:0];
      r.accepted = (r.status == STATUS_OK) && (val <= longint'(cutoff));
      return r;
   endfunction

   // Track the cutoff, predict on each accepted pair, compare each accepted result.
   always @(posedge clock) begin
      longint c[12];
      bond_result_type want;
      if (reset) begin
         cutoff_shadow <= CUTOFF_RESET;
         energy_queue.delete();
         fail_count = 0;
         result_count <= 0;
         saturated_count <= 0;
         taken_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) cutoff_shadow <= csr_mon.energy_cutoff;
         if (req_mon.valid && req_mon.ready) begin
            c = '{req_mon.donor_nitrogen_x, req_mon.donor_nitrogen_y, req_mon.donor_nitrogen_z,
                  req_mon.donor_hydrogen_x, req_mon.donor_hydrogen_y, req_mon.donor_hydrogen_z,
                  req_mon.acceptor_oxygen_x, req_mon.acceptor_oxygen_y,
                  req_mon.acceptor_oxygen_z, req_mon.acceptor_carbon_x,
                  req_mon.acceptor_carbon_y, req_mon.acceptor_carbon_z};
            energy_queue = {energy_queue, predict_bond(c, cutoff_shadow)};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count <= result_count + 1;
            if (rsp_mon.status == STATUS_SATURATED) saturated_count <= saturated_count + 1;
            if (rsp_mon.accepted) taken_count <= taken_count + 1;
            if (energy_queue.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               want = energy_queue.pop_front();
               if (rsp_mon.bond_energy !== want.energy)
                  report_mismatch("bond_energy", rsp_mon.bond_energy, want.energy);
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.accepted !== want.accepted)
                  report_mismatch("accepted", rsp_mon.accepted, want.accepted);
            end
         end
      end
      pending_count <= energy_queue.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_hbond_energy_kernel.sv =====
// Testbench top for the hydrogen-bond energy kernel: stimulus, cutoff writes and the verdict.
`timescale 1ns / 100ps
`default_nettype none

module tb_hbond_energy_kernel;
   import hbek_pkg::*;

   localparam int PIPE_DEPTH  = 40;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count, saturated_count, taken_count;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic recv_hold = 1'b0;
   int   pair_count = 0;

   hbek_req_if req_bus ();
   hbek_rsp_if rsp_bus ();
   hbek_csr_if csr_bus ();

   hbond_energy_kernel dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   hbek_checker bond_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus.sink),
      .rsp_mon         (rsp_bus.sink),
      .csr_mon         (csr_bus.sink),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .saturated_count (saturated_count),
      .taken_count     (taken_count)
   );

   always #1 clock = ~clock;

   // Give up after a generous number of cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stalls plus a long hold-off when requested.
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Send one pair word and wait until it is taken, idling at random first.
   task automatic send_pair(input coord_type c[12]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.donor_nitrogen_x, req_bus.donor_nitrogen_y, req_bus.donor_nitrogen_z,
       req_bus.donor_hydrogen_x, req_bus.donor_hydrogen_y, req_bus.donor_hydrogen_z,
       req_bus.acceptor_oxygen_x, req_bus.acceptor_oxygen_y, req_bus.acceptor_oxygen_z,
       req_bus.acceptor_carbon_x, req_bus.acceptor_carbon_y, req_bus.acceptor_carbon_z}
         <= {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pair_count++;
      @(negedge clock);
   endtask

   // Wait for all results, then write a new cutoff while the pipeline is empty.
   task automatic write_cutoff(input energy_type value);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.energy_cutoff <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   // Plausible backbone geometry: N-O near 2.1..3.8 A, roughly collinear N-H-O and O-C.
   function automatic void bond_geometry(output coord_type c[12]);
      int base[3];
      int jit;
      jit = $urandom_range(3) == 0 ? 200 : 40;
      for (int i = 0; i < 3; i++) base[i] = $urandom_range(60000) - 30000;
      c[0] = base[0];
      c[1] = base[1];
      c[2] = base[2];
      c[3] = base[0] + 256 + $urandom_range(2*jit) - jit;
      c[4] = base[1] + $urandom_range(2*jit) - jit;
      c[5] = base[2] + $urandom_range(2*jit) - jit;
      c[6] = base[0] + 640 + $urandom_range(400) - 100;
      c[7] = base[1] + $urandom_range(2*jit) - jit;
      c[8] = base[2] + $urandom_range(2*jit) - jit;
      c[9] = c[6] + 310 + $urandom_range(2*jit) - jit;
      c[10] = c[7] + $urandom_range(2*jit) - jit;
      c[11] = c[8] + $urandom_range(2*jit) - jit;
   endfunction

   // One random pair: mostly good geometry, some full-range noise, close contacts and collapsed points.
   task automatic random_pair();
      coord_type c[12];
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         bond_geometry(c);
      end else if (pick < 80) begin
         foreach (c[i]) c[i] = rand_coord();
      end else if (pick < 90) begin
         // Close contact: N-O well inside the repulsive range.
         bond_geometry(c);
         c[6] = c[0] + $urandom_range(200) + 1;
         c[9] = c[6] + 300;
      end else begin
         bond_geometry(c);
         case ($urandom_range(3))
            0: begin
               c[6] = c[0]; c[7] = c[1]; c[8] = c[2];
            end
            1: begin
               c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
            end
            2: begin
               c[3] = c[6]; c[4] = c[7]; c[5] = c[8];
            end
            default: begin
               c[9] = c[6]; c[10] = c[7]; c[11] = c[8];
            end
         endcase
      end
      send_pair(c);
   endtask

   initial begin
      coord_type c[12];
      energy_type cutoffs[6];
      int phase;
      req_bus.valid = 1'b0;
      {req_bus.donor_nitrogen_x, req_bus.donor_nitrogen_y, req_bus.donor_nitrogen_z,
       req_bus.donor_hydrogen_x, req_bus.donor_hydrogen_y, req_bus.donor_hydrogen_z,
       req_bus.acceptor_oxygen_x, req_bus.acceptor_oxygen_y, req_bus.acceptor_oxygen_z,
       req_bus.acceptor_carbon_x, req_bus.acceptor_carbon_y, req_bus.acceptor_carbon_z} = '0;
      csr_bus.valid = 1'b0;
      csr_bus.energy_cutoff = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pairs: typical bond, zero distance, each degenerate angle, far pair,
      // extreme coordinates, close contact, and a pair with the angle pointing away.
      foreach (c[i]) c[i] = 0;
      c[3] = 256; c[6] = 750; c[9] = 1060;
      send_pair(c);
      c[6] = 0;
      send_pair(c);
      c[6] = 750; c[3] = 0;
      send_pair(c);
      c[3] = 750;
      send_pair(c);
      c[3] = 256; c[9] = 750;
      send_pair(c);
      c[9] = 1060; c[6] = 70000;
      send_pair(c);
      foreach (c[i]) c[i] = (i % 2) ? 20'sh80000 : 20'sh7FFFF;
      send_pair(c);
      foreach (c[i]) c[i] = (i % 3 == 0) ? 20'sh7FFFF : 20'sh80000;
      c[7] = 20'sh7FFFF;
      send_pair(c);
      foreach (c[i]) c[i] = 0;
      c[3] = 20; c[6] = 40; c[9] = 80;
      send_pair(c);
      c[3] = -256; c[6] = 750; c[9] = 400;
      send_pair(c);
      c[3] = 200; c[4] = 10; c[6] = 560; c[9] = 870; c[10] = -5;
      send_pair(c);
      foreach (c[i]) c[i] = 20'sh7FFFF;
      c[6] = 20'sh80000;
      send_pair(c);

      // Random phases across cutoff settings, the extremes among them.
      cutoffs = '{-24'sd1, ENERGY_MIN, -24'sd65536, -24'sd200000, -24'sd32768, -24'sd5000};
      for (phase = 0; phase < 6; phase++) begin
         write_cutoff(cutoffs[phase]);
         send_idle_pct = phase < 2 ? 29 : (phase < 4 ? 47 : 0);
         recv_idle_pct = phase < 2 ? 47 : (phase < 4 ? 29 : 0);
         if (phase == 5) begin
            // Hold the result side off long enough for the pipeline to fill.
            fork
               begin
                  recv_hold = 1'b1;
                  repeat (150) @(negedge clock);
                  recv_hold = 1'b0;
               end
               repeat (60) random_pair();
            join
         end
         repeat (80) random_pair();
      end

      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 10) @(negedge clock);
      $display("Ran %0d pairs over six cutoff settings and several stall patterns.", pair_count);
      $display("Results: %0d, saturated: %0d, accepted bonds: %0d.",
               result_count, saturated_count, taken_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/hbek_pkg.sv
hdl/hbek_if.sv
hdl/hbond_energy_kernel.sv
tb/hbek_checker.sv
tb/tb_hbond_energy_kernel.sv
